// ===== rtl/core/krs_pkg.sv =====
// Keyed record store: shared word types, operation and status codes, FNV-1a step.
// Depends on nothing; used by the engine top level.
package krs_pkg;

  localparam int LEN_W = 11;

  localparam logic [1:0] OP_SAVE   = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_FORMAT = 2'd2;
  localparam logic [1:0] OP_IDLE   = 2'd3;

  localparam logic [2:0] ST_MORE     = 3'd0;
  localparam logic [2:0] ST_OK       = 3'd1;
  localparam logic [2:0] ST_NO_SLOT  = 3'd2;
  localparam logic [2:0] ST_LEN_BAD  = 3'd3;
  localparam logic [2:0] ST_HASH_BAD = 3'd4;

  localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

  typedef struct packed {
    logic [1:0]       operation;
    logic [31:0]      key;
    logic [LEN_W-1:0] record_length;
    logic [7:0]       data_byte;
    logic             last;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  read_byte;
    logic [12:0] bytes_used;
    logic        usage_warning;
    logic        run_end;
  } rsp_t;

  // One FNV-1a byte step
  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return 32'(x * FNV_PRIME);
  endfunction

endpackage

// ===== rtl/core/krs_ram.sv =====
// Generic single-port RAM with registered read.
// Depends on nothing.
module krs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one word a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/keyed_record_store_engine.sv =====
// Keyed record store engine: sequencer around one byte-wide pool RAM.
// Depends on krs_pkg and krs_ram.
//
//  channel   | handshake            | word
//  ----------+----------------------+---------------------
//  request   | start high, busy low | krs_pkg::req_t
//  response  | done strobe, 1 cycle | krs_pkg::rsp_t
//
// A save byte goes through the byte step and the response; a load byte also captures
// the read byte before the response. The last save word pads the record with zeros
// and then writes the hash. The first word of a run walks records, stepping over each
// one until the walk ends; a load then hashes the stored data byte by byte. Format
// and a clear from a bad length sweep the pool at one byte a cycle.
// After reset a clearing pass over the whole pool holds busy high.
// Results cannot be stalled; done is high for exactly one cycle.
module keyed_record_store_engine #(
  parameter int POOL_BYTES   = 4096,
  parameter int HEADER_BYTES = 16,
  parameter int MAX_RECORDS  = 100,
  parameter int MAX_DATA     = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  krs_pkg::req_t request,
  output logic          busy,
  output logic          done,
  output krs_pkg::rsp_t response
);

  localparam int PAW = $clog2(POOL_BYTES);
  localparam int XW  = $clog2(POOL_BYTES + MAX_DATA + 64) + 1;
  localparam int NW  = $clog2(MAX_RECORDS + 1);
  localparam int LW  = krs_pkg::LEN_W;
  localparam logic [XW+2:0] WARN_LIMIT = (XW+3)'(POOL_BYTES * 4);

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_WCHK  = 5'd2;
  localparam logic [4:0] S_WKEY  = 5'd3;
  localparam logic [4:0] S_WLEN  = 5'd4;
  localparam logic [4:0] S_CLAIM = 5'd5;
  localparam logic [4:0] S_HDR2  = 5'd6;
  localparam logic [4:0] S_LLEN  = 5'd7;
  localparam logic [4:0] S_LCMP  = 5'd8;
  localparam logic [4:0] S_HISS  = 5'd9;
  localparam logic [4:0] S_HCAP  = 5'd10;
  localparam logic [4:0] S_HCHK  = 5'd11;
  localparam logic [4:0] S_BYTE  = 5'd12;
  localparam logic [4:0] S_BCAP  = 5'd13;
  localparam logic [4:0] S_AFTER = 5'd14;
  localparam logic [4:0] S_PAD   = 5'd15;
  localparam logic [4:0] S_TAIL  = 5'd16;
  localparam logic [4:0] S_RESP  = 5'd17;
  localparam logic [4:0] S_RD4   = 5'd18;
  localparam logic [4:0] S_WR4   = 5'd19;

  logic [4:0]    state;
  logic [4:0]    ret;
  krs_pkg::req_t req;
  logic          fmt_q;
  logic          idle_q;
  logic          run_load;
  logic [LW-1:0] rlen;
  logic [2:0]    rs;
  logic [LW-1:0] pos;
  logic [LW-1:0] idx;
  logic [31:0]   hash;
  logic [XW-1:0] rec;
  logic [XW-1:0] addr;
  logic [XW-1:0] base;
  logic [XW-1:0] clr_addr;
  logic [XW-1:0] used;
  logic          warned;
  logic          in_run;
  logic [NW-1:0] nrec;
  logic [2:0]    cnt;
  logic [31:0]   acc;
  logic [31:0]   wval;
  logic [7:0]    rbyte;
  logic          rd_oob;

  logic [XW-1:0] mem_addr;
  logic          mem_we;
  logic [7:0]    mem_wd;
  logic [7:0]    mem_rd;
  logic [7:0]    rdz;
  logic [XW-1:0] top;
  logic [XW-1:0] used_new;

  // Drive the single RAM port from the sequencer state
  always_comb begin
    mem_addr = '0;
    mem_we   = 1'b0;
    mem_wd   = 8'd0;
    case (state)
      S_CLR: begin
        mem_addr = clr_addr;
        mem_we   = 1'b1;
      end
      S_RD4: begin
        mem_addr = base + XW'(cnt);
      end
      S_WR4: begin
        mem_addr = base + XW'(cnt);
        mem_we   = 1'b1;
        mem_wd   = wval[7:0];
      end
      S_HISS: begin
        mem_addr = rec + XW'(8) + XW'(idx);
      end
      S_BYTE: begin
        mem_addr = rec + XW'(8) + XW'(pos);
        mem_we   = !run_load && (rs == krs_pkg::ST_MORE) && (pos < rlen);
        mem_wd   = req.data_byte;
      end
      S_PAD: begin
        mem_addr = rec + XW'(8) + XW'(pos);
        mem_we   = pos < rlen;
      end
      default: begin
        mem_addr = '0;
      end
    endcase
  end

  krs_ram #(.WIDTH(8), .DEPTH(2 ** PAW)) u_pool (
    .clk   (clk),
    .we    (mem_we && (mem_addr < XW'(POOL_BYTES))),
    .addr  (mem_addr[PAW-1:0]),
    .wdata (mem_wd),
    .rdata (mem_rd)
  );

  // Bytes beyond the pool end read as zero
  assign rdz      = rd_oob ? 8'd0 : mem_rd;
  assign top      = rec + XW'(12) + XW'(rlen);
  assign used_new = (top > used) ? top : used;
  assign busy     = (state != S_IDLE);

  // Main sequencer
  always_ff @(posedge clk) begin
    rd_oob <= mem_addr >= XW'(POOL_BYTES);
    if (rst) begin
      state    <= S_CLR;
      ret      <= S_IDLE;
      clr_addr <= '0;
      used     <= XW'(HEADER_BYTES);
      warned   <= 1'b0;
      in_run   <= 1'b0;
      rs       <= krs_pkg::ST_MORE;
      pos      <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLR: begin
          if (clr_addr == XW'(POOL_BYTES - 1)) begin
            state <= ret;
          end else begin
            clr_addr <= clr_addr + XW'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            req    <= request;
            rbyte  <= 8'd0;
            fmt_q  <= 1'b0;
            idle_q <= 1'b0;
            if (request.operation == krs_pkg::OP_FORMAT) begin
              fmt_q    <= 1'b1;
              used     <= XW'(HEADER_BYTES);
              warned   <= 1'b0;
              in_run   <= 1'b0;
              rs       <= krs_pkg::ST_MORE;
              pos      <= '0;
              clr_addr <= '0;
              ret      <= S_RESP;
              state    <= S_CLR;
            end else if (!in_run && request.operation == krs_pkg::OP_IDLE) begin
              idle_q <= 1'b1;
              state  <= S_RESP;
            end else if (!in_run) begin
              run_load <= (request.operation == krs_pkg::OP_LOAD);
              rlen     <= request.record_length;
              rs       <= krs_pkg::ST_MORE;
              pos      <= '0;
              hash     <= krs_pkg::FNV_BASIS;
              rec      <= '0;
              if (XW'(request.record_length) > XW'(MAX_DATA)) begin
                rs    <= krs_pkg::ST_LEN_BAD;
                state <= S_BYTE;
              end else begin
                addr  <= XW'(HEADER_BYTES);
                nrec  <= '0;
                state <= S_WCHK;
              end
            end else begin
              state <= S_BYTE;
            end
          end
        end
        // Walk: bound checks, then fetch the key
        S_WCHK: begin
          if (addr >= XW'(POOL_BYTES) || nrec >= NW'(MAX_RECORDS)) begin
            rs    <= krs_pkg::ST_NO_SLOT;
            state <= S_BYTE;
          end else begin
            nrec  <= nrec + NW'(1);
            base  <= addr;
            cnt   <= 3'd0;
            ret   <= S_WKEY;
            state <= S_RD4;
          end
        end
        S_WKEY: begin
          if (acc == req.key || acc == 32'd0) begin
            state <= S_CLAIM;
          end else begin
            base  <= addr + XW'(4);
            cnt   <= 3'd0;
            ret   <= S_WLEN;
            state <= S_RD4;
          end
        end
        S_WLEN: begin
          if (acc > 32'(MAX_DATA)) begin
            clr_addr <= addr;
            ret      <= S_CLAIM;
            state    <= S_CLR;
          end else begin
            addr  <= addr + XW'(12) + XW'(acc);
            state <= S_WCHK;
          end
        end
        // Claim the slot: save writes key and length, load writes key
        S_CLAIM: begin
          if (!run_load && (addr + XW'(12) + XW'(rlen) > XW'(POOL_BYTES))) begin
            rs    <= krs_pkg::ST_NO_SLOT;
            state <= S_BYTE;
          end else begin
            rec   <= addr;
            base  <= addr;
            wval  <= req.key;
            cnt   <= 3'd0;
            ret   <= run_load ? S_LLEN : S_HDR2;
            state <= S_WR4;
          end
        end
        S_HDR2: begin
          base  <= rec + XW'(4);
          wval  <= 32'(rlen);
          cnt   <= 3'd0;
          ret   <= S_BYTE;
          state <= S_WR4;
        end
        S_LLEN: begin
          base  <= rec + XW'(4);
          cnt   <= 3'd0;
          ret   <= S_LCMP;
          state <= S_RD4;
        end
        S_LCMP: begin
          if (acc != 32'(rlen)) begin
            rs    <= krs_pkg::ST_LEN_BAD;
            state <= S_BYTE;
          end else begin
            hash  <= krs_pkg::FNV_BASIS;
            idx   <= '0;
            state <= S_HISS;
          end
        end
        // Hash the stored data, then fetch the stored hash
        S_HISS: begin
          if (idx < rlen) begin
            state <= S_HCAP;
          end else begin
            base  <= rec + XW'(8) + XW'(rlen);
            cnt   <= 3'd0;
            ret   <= S_HCHK;
            state <= S_RD4;
          end
        end
        S_HCAP: begin
          hash  <= krs_pkg::fnv_step(hash, rdz);
          idx   <= idx + LW'(1);
          state <= S_HISS;
        end
        S_HCHK: begin
          if (hash != acc) begin
            rs <= krs_pkg::ST_HASH_BAD;
          end
          state <= S_BYTE;
        end
        // One data byte of the current word
        S_BYTE: begin
          if (rs == krs_pkg::ST_MORE && pos < rlen) begin
            pos <= pos + LW'(1);
            if (run_load) begin
              state <= S_BCAP;
            end else begin
              hash  <= krs_pkg::fnv_step(hash, req.data_byte);
              state <= S_AFTER;
            end
          end else begin
            state <= S_AFTER;
          end
        end
        S_BCAP: begin
          rbyte <= rdz;
          state <= S_AFTER;
        end
        S_AFTER: begin
          if (req.last && rs == krs_pkg::ST_MORE && !run_load) begin
            state <= S_PAD;
          end else begin
            state <= S_RESP;
          end
        end
        // Pad a short save with zeros, then store the hash
        S_PAD: begin
          if (pos < rlen) begin
            hash <= krs_pkg::fnv_step(hash, 8'd0);
            pos  <= pos + LW'(1);
          end else begin
            base  <= rec + XW'(8) + XW'(rlen);
            wval  <= hash;
            cnt   <= 3'd0;
            ret   <= S_TAIL;
            state <= S_WR4;
          end
        end
        S_TAIL: begin
          used <= used_new;
          if ((XW+3)'(used_new) * (XW+3)'(5) > WARN_LIMIT) begin
            warned <= 1'b1;
          end
          state <= S_RESP;
        end
        S_RESP: begin
          done                   <= 1'b1;
          response.read_byte     <= rbyte;
          response.bytes_used    <= 13'(used);
          response.usage_warning <= warned;
          if (fmt_q) begin
            response.status  <= krs_pkg::ST_OK;
            response.run_end <= 1'b1;
          end else if (idle_q) begin
            response.status  <= krs_pkg::ST_MORE;
            response.run_end <= 1'b0;
          end else begin
            response.run_end <= req.last;
            in_run           <= !req.last;
            if (!req.last) begin
              response.status <= krs_pkg::ST_MORE;
            end else if (rs != krs_pkg::ST_MORE) begin
              response.status <= rs;
            end else begin
              response.status <= krs_pkg::ST_OK;
            end
          end
          state <= S_IDLE;
        end
        // Read four bytes little-endian, one issued per cycle
        S_RD4: begin
          if (cnt != 3'd0) begin
            acc <= {rdz, acc[31:8]};
          end
          if (cnt == 3'd4) begin
            state <= ret;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        // Write four bytes little-endian
        S_WR4: begin
          wval <= {8'd0, wval[31:8]};
          if (cnt == 3'd3) begin
            state <= ret;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Only the response state raises the strobe
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_RESP)
    else $error("done without response state");

  // A final word leaves no run open
  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    done && response.run_end |-> !in_run)
    else $error("run still open after run end");

  // A nonzero status only comes with run end
  a_status_end: assert property (@(posedge clk) disable iff (rst)
    done && response.status != krs_pkg::ST_MORE |-> response.run_end)
    else $error("final status without run end");

endmodule
